>>> rtl/ascii_xy_offset_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// ascii_xy_offset_frame_parser assertion macros
// shared property shapes for the frame parser checker
// ----------------------------------------------------------------------------
`ifndef ASCII_XY_OFFSET_FRAME_PARSER_MACROS_SVH
`define ASCII_XY_OFFSET_FRAME_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define AXOFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define AXOFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/axofp_pkg.sv
// ----------------------------------------------------------------------------
// axofp_pkg
// types and codes shared by the ascii x/y offset frame parser
// ----------------------------------------------------------------------------
package axofp_pkg;

    // result kinds
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_COMMIT  = 2'd1;
    localparam logic [1:0] EV_DISCARD = 2'd2;

    localparam int RES_DATA_W = 96;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]         event_res;
        logic signed [15:0] x_offset;
        logic signed [15:0] y_offset;
        logic [31:0]        good_frames;
        logic [31:0]        dropped_frames;
    } result_t;

endpackage

>>> rtl/ascii_xy_offset_frame_parser.sv
// ----------------------------------------------------------------------------
// ascii_xy_offset_frame_parser
// parses X[+|-]digits Y[+|-]digits frames into clamped 16-bit offsets
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                   tuser
//  s_axis    in   [7:0] data_byte                         [0] command (1 = flush)
//  m_axis    out  [15:0] x, [31:16] y, [63:32] good,      [1:0] event_res
//                 [95:64] dropped
//
//  one item per cycle while the output is not stalled; each item goes
//  through an input register, the parser update and an output register.
//  rst_n clears parser state, counters and both valid flags.
//  a stalled output holds its item while one more item waits in the input
//  register; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module ascii_xy_offset_frame_parser #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // x_offset, y_offset, good_frames, dropped_frames
    output logic [1:0]  m_tuser    // [1:0] event_res
);

    logic               in_vld_reg, in_vld_next;
    axofp_pkg::item_t   in_item_reg;
    logic               out_vld_reg, out_vld_next;
    axofp_pkg::result_t out_res_reg;
    axofp_pkg::result_t res;
    logic               out_free;
    logic               step;
    logic               s_fire;

    assign out_free = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_fire)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (step)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.command   <= s_tuser;
            in_item_reg.data_byte <= s_tdata;
        end
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    axofp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.event_res;
    assign m_tdata  = {out_res_reg.dropped_frames, out_res_reg.good_frames,
                       out_res_reg.y_offset, out_res_reg.x_offset};

endmodule

>>> rtl/axofp_core.sv
// ----------------------------------------------------------------------------
// axofp_core
// parser state and combinational update for one item
// ----------------------------------------------------------------------------
module axofp_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  axofp_pkg::item_t  item,
    output axofp_pkg::result_t result
);

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_X    = 2'd1;
    localparam logic [1:0] PH_Y    = 2'd2;

    localparam logic [15:0] MAG_LIMIT  = 16'h8000;
    localparam logic [15:0] OFFSET_MAX = 16'h7FFF;
    localparam logic [15:0] OFFSET_MIN = 16'h8000;

    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_Y_UP   = 8'h59;
    localparam logic [7:0] CH_Y_LO   = 8'h79;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    function automatic logic [15:0] to_offset(input logic [15:0] mag, input logic neg);
        logic [15:0] r;
        if (neg)
        begin
            r = (mag >= MAG_LIMIT) ? OFFSET_MIN : (16'h0000 - mag);
        end
        else
        begin
            r = (mag > OFFSET_MAX) ? OFFSET_MAX : mag;
        end
        return r;
    endfunction

    // mag * 10 + d, saturated at 32768
    function automatic logic [15:0] add_digit(input logic [15:0] mag, input logic [3:0] d);
        logic [19:0] v;
        v = 20'({mag, 3'b000}) + 20'({mag, 1'b0}) + 20'(d);
        return (v > 20'(MAG_LIMIT)) ? MAG_LIMIT : v[15:0];
    endfunction

    logic [1:0]             phase_reg, phase_next;
    logic                   x_neg_reg, x_neg_next;
    logic                   y_neg_reg, y_neg_next;
    logic [15:0]            x_mag_reg, x_mag_next;
    logic [15:0]            y_mag_reg, y_mag_next;
    logic                   x_seen_reg, x_seen_next;
    logic                   y_seen_reg, y_seen_next;
    logic [15:0]            last_x_reg, last_x_next;
    logic [15:0]            last_y_reg, last_y_next;
    logic [COUNT_WIDTH-1:0] good_reg, good_next;
    logic [COUNT_WIDTH-1:0] bad_reg, bad_next;

    logic       is_x, is_y, is_sign, is_digit, is_minus;
    logic [3:0] digit;
    logic       y_ready;
    logic       do_commit, do_discard, do_clear, enter_x;
    logic [1:0] ev;

    always_comb
    begin
        is_x     = (item.data_byte == CH_X_UP) || (item.data_byte == CH_X_LO);
        is_y     = (item.data_byte == CH_Y_UP) || (item.data_byte == CH_Y_LO);
        is_minus = (item.data_byte == CH_MINUS);
        is_sign  = (item.data_byte == CH_PLUS) || is_minus;
        is_digit = (item.data_byte >= CH_ZERO) && (item.data_byte <= CH_NINE);
        digit    = item.data_byte[3:0];
        // unused phase code behaves as the y phase
        y_ready  = phase_reg[1] && y_seen_reg;

        phase_next  = phase_reg;
        x_neg_next  = x_neg_reg;
        y_neg_next  = y_neg_reg;
        x_mag_next  = x_mag_reg;
        y_mag_next  = y_mag_reg;
        x_seen_next = x_seen_reg;
        y_seen_next = y_seen_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        good_next   = good_reg;
        bad_next    = bad_reg;

        do_commit  = 1'b0;
        do_discard = 1'b0;
        do_clear   = 1'b0;
        enter_x    = 1'b0;

        if (item.command)
        begin
            do_commit = y_ready;
        end
        else if (is_x)
        begin
            do_commit = y_ready;
            do_clear  = 1'b1;
            enter_x   = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                end
                PH_X:
                begin
                    if (is_sign && !x_seen_reg && (x_mag_reg == 16'd0))
                    begin
                        x_neg_next = is_minus;
                    end
                    else if (is_digit)
                    begin
                        x_mag_next  = add_digit(x_mag_reg, digit);
                        x_seen_next = 1'b1;
                    end
                    else if (is_y && x_seen_reg)
                    begin
                        phase_next = PH_Y;
                    end
                    else
                    begin
                        do_discard = 1'b1;
                    end
                end
                default:
                begin
                    if (is_sign && !y_seen_reg && (y_mag_reg == 16'd0))
                    begin
                        y_neg_next = is_minus;
                    end
                    else if (is_digit)
                    begin
                        y_mag_next  = add_digit(y_mag_reg, digit);
                        y_seen_next = 1'b1;
                    end
                    else if (y_seen_reg)
                    begin
                        do_commit = 1'b1;
                    end
                    else
                    begin
                        do_discard = 1'b1;
                    end
                end
            endcase
        end

        if (do_commit)
        begin
            last_x_next = to_offset(x_mag_reg, x_neg_reg);
            last_y_next = to_offset(y_mag_reg, y_neg_reg);
            good_next   = good_reg + COUNT_WIDTH'(1);
        end
        if (do_discard)
        begin
            bad_next = bad_reg + COUNT_WIDTH'(1);
        end
        if (do_commit || do_discard || do_clear)
        begin
            phase_next  = PH_WAIT;
            x_neg_next  = 1'b0;
            y_neg_next  = 1'b0;
            x_mag_next  = 16'd0;
            y_mag_next  = 16'd0;
            x_seen_next = 1'b0;
            y_seen_next = 1'b0;
        end
        if (enter_x)
        begin
            phase_next = PH_X;
        end

        if (do_commit)
        begin
            ev = axofp_pkg::EV_COMMIT;
        end
        else if (do_discard)
        begin
            ev = axofp_pkg::EV_DISCARD;
        end
        else
        begin
            ev = axofp_pkg::EV_NONE;
        end

        result.event_res      = ev;
        result.x_offset       = $signed(last_x_next);
        result.y_offset       = $signed(last_y_next);
        result.good_frames    = 32'(good_next);
        result.dropped_frames = 32'(bad_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            x_neg_reg  <= 1'b0;
            y_neg_reg  <= 1'b0;
            x_mag_reg  <= 16'd0;
            y_mag_reg  <= 16'd0;
            x_seen_reg <= 1'b0;
            y_seen_reg <= 1'b0;
            last_x_reg <= 16'd0;
            last_y_reg <= 16'd0;
            good_reg   <= '0;
            bad_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            x_neg_reg  <= x_neg_next;
            y_neg_reg  <= y_neg_next;
            x_mag_reg  <= x_mag_next;
            y_mag_reg  <= y_mag_next;
            x_seen_reg <= x_seen_next;
            y_seen_reg <= y_seen_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            good_reg   <= good_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

>>> rtl/axofp_checker.sv
// ----------------------------------------------------------------------------
// axofp_checker
// port-level checks of the frame parser, bound to the top level
// ----------------------------------------------------------------------------
`include "ascii_xy_offset_frame_parser_macros.svh"

module axofp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic        m_fire;
    logic        prev_vld_reg;
    logic [95:0] prev_data_reg;

    assign m_fire = m_tvalid && m_tready;

    // last delivered item, for checking field changes between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_vld_reg  <= 1'b0;
            prev_data_reg <= '0;
        end
        else if (m_fire)
        begin
            prev_vld_reg  <= 1'b1;
            prev_data_reg <= m_tdata;
        end
    end

    `AXOFP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output item changed while stalled")

    `AXOFP_ASSERT_NOW(a_ready_only_full, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")

    `AXOFP_ASSERT_NOW(a_good_step, m_fire && prev_vld_reg, (m_tuser == axofp_pkg::EV_COMMIT) ? ((m_tdata[63:32] == prev_data_reg[63:32] + 32'd1) || (m_tdata[63:32] == 32'd0)) : (m_tdata[63:32] == prev_data_reg[63:32]), "good count moved without a commit")

    `AXOFP_ASSERT_NOW(a_bad_step, m_fire && prev_vld_reg, (m_tuser == axofp_pkg::EV_DISCARD) ? ((m_tdata[95:64] == prev_data_reg[95:64] + 32'd1) || (m_tdata[95:64] == 32'd0)) : (m_tdata[95:64] == prev_data_reg[95:64]), "bad count moved without a discard")

    `AXOFP_ASSERT_NOW(a_offsets_hold, m_fire && prev_vld_reg && (m_tuser != axofp_pkg::EV_COMMIT), m_tdata[31:0] == prev_data_reg[31:0], "offsets changed without a commit")

endmodule

bind ascii_xy_offset_frame_parser axofp_checker u_axofp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/ascii_xy_offset_frame_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_xy_offset_frame_parser_tb
// drives X/Y offset frames, noise bytes and flushes into the parser stream
// port, tracks the parser state alongside the block and checks every result
// item in order; both handshakes idle at random, with one long output stall
// ----------------------------------------------------------------------------
module ascii_xy_offset_frame_parser_tb;

    localparam int  N_ITEMS     = 1950;
    localparam int  LIMIT       = 200000;
    localparam int  HOLD_AT     = 300;
    localparam int  HOLD_CYCLES = 120;
    localparam int  DRAIN       = 8;
    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;
    localparam logic [15:0] MAG_SAT = 16'd32768;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_X    = 2'd1;
    localparam logic [1:0] PH_Y    = 2'd2;

    typedef struct {
        logic               cmd;
        logic [7:0]         ch;
        bit                 known;
        axofp_pkg::result_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;

    // parser shadow state
    logic [1:0]  ph;
    logic        x_neg, y_neg, x_dig, y_dig;
    logic [15:0] x_mag, y_mag;
    logic [15:0] last_x, last_y;
    logic [31:0] good_cnt, bad_cnt;

    axofp_pkg::result_t pending_q [$];
    int          n_sent = 0;
    int          n_got = 0;
    int          n_errors = 0;
    int          cycle_cnt = 0;

    dir_row_t dir_rows [0:24] = '{
        '{CMD_FLUSH, 8'h00, 1'b1, '{axofp_pkg::EV_NONE, 16'sd0, 16'sd0, 32'd0, 32'd0}},
        '{CMD_BYTE,  8'h00, 1'b1, '{axofp_pkg::EV_NONE, 16'sd0, 16'sd0, 32'd0, 32'd0}},
        '{CMD_BYTE,  8'hFF, 1'b1, '{axofp_pkg::EV_NONE, 16'sd0, 16'sd0, 32'd0, 32'd0}},
        '{CMD_BYTE,  "x",   1'b0, '0},
        '{CMD_BYTE,  "+",   1'b0, '0},
        '{CMD_BYTE,  "-",   1'b0, '0},
        '{CMD_BYTE,  "7",   1'b0, '0},
        '{CMD_BYTE,  "y",   1'b0, '0},
        '{CMD_BYTE,  "-",   1'b0, '0},
        '{CMD_BYTE,  "0",   1'b0, '0},
        // flush command closes the frame, minus zero reads as zero
        '{CMD_FLUSH, 8'hFF, 1'b1, '{axofp_pkg::EV_COMMIT, -16'sd7, 16'sd0, 32'd1, 32'd0}},
        '{CMD_BYTE,  "X",   1'b0, '0},
        '{CMD_BYTE,  "9",   1'b0, '0},
        '{CMD_BYTE,  "9",   1'b0, '0},
        '{CMD_BYTE,  "9",   1'b0, '0},
        '{CMD_BYTE,  "9",   1'b0, '0},
        '{CMD_BYTE,  "9",   1'b0, '0},
        '{CMD_BYTE,  "Y",   1'b0, '0},
        '{CMD_BYTE,  "3",   1'b0, '0},
        // sign after y digits ends the frame, saturated x clamps
        '{CMD_BYTE,  "+",   1'b1, '{axofp_pkg::EV_COMMIT, 16'sd32767, 16'sd3, 32'd2, 32'd0}},
        '{CMD_BYTE,  "X",   1'b0, '0},
        '{CMD_BYTE,  "5",   1'b0, '0},
        // sign after x digits is malformed
        '{CMD_BYTE,  "-",   1'b1, '{axofp_pkg::EV_DISCARD, 16'sd32767, 16'sd3, 32'd2, 32'd1}},
        '{CMD_BYTE,  "X",   1'b0, '0},
        // y with no x digits is malformed
        '{CMD_BYTE,  "y",   1'b1, '{axofp_pkg::EV_DISCARD, 16'sd32767, 16'sd3, 32'd2, 32'd2}}
    };

    ascii_xy_offset_frame_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tuser  (s_tuser),   // [0] command
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // x_offset, y_offset, good_frames, dropped_frames
        .m_tuser  (m_tuser)    // [1:0] event_res
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("%0t timeout with %0d results pending", $time, pending_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // parser shadow
    // ------------------------------------------------------------------------
    function automatic void clear_fields();
        ph    = PH_WAIT;
        x_neg = 1'b0;
        y_neg = 1'b0;
        x_mag = 16'd0;
        y_mag = 16'd0;
        x_dig = 1'b0;
        y_dig = 1'b0;
    endfunction

    function automatic logic [15:0] signed_offset(input logic [15:0] mag, input logic neg);
        if (neg)
            return (mag >= MAG_SAT) ? 16'h8000 : 16'(17'd0 - {1'b0, mag});
        return (mag > 16'd32767) ? 16'h7FFF : mag;
    endfunction

    function automatic logic [15:0] push_digit(input logic [15:0] mag, input logic [7:0] ch);
        logic [31:0] v;
        v = {16'd0, mag} * 32'd10 + {24'd0, ch - 8'h30};
        return (v > {16'd0, MAG_SAT}) ? MAG_SAT : v[15:0];
    endfunction

    function automatic logic [1:0] take_frame();
        last_x   = signed_offset(x_mag, x_neg);
        last_y   = signed_offset(y_mag, y_neg);
        good_cnt = good_cnt + 32'd1;
        clear_fields();
        return axofp_pkg::EV_COMMIT;
    endfunction

    function automatic logic [1:0] drop_frame();
        bad_cnt = bad_cnt + 32'd1;
        clear_fields();
        return axofp_pkg::EV_DISCARD;
    endfunction

    function automatic axofp_pkg::result_t parse_item(input logic cmd, input logic [7:0] ch);
        axofp_pkg::result_t r;
        logic    is_digit, is_sign, is_x, is_y;
        is_digit = (ch >= "0") && (ch <= "9");
        is_sign  = (ch == "+") || (ch == "-");
        is_x     = (ch == "X") || (ch == "x");
        is_y     = (ch == "Y") || (ch == "y");
        r.event_res = axofp_pkg::EV_NONE;
        if (cmd == CMD_FLUSH)
        begin
            if (ph == PH_Y && y_dig)
                r.event_res = take_frame();
        end
        else if (is_x)
        begin
            if (ph == PH_Y && y_dig)
                r.event_res = take_frame();
            else
                clear_fields();
            ph = PH_X;
        end
        else if (ph == PH_WAIT)
        begin
            r.event_res = axofp_pkg::EV_NONE;
        end
        else if (ph == PH_X)
        begin
            if (is_sign && !x_dig && x_mag == 16'd0)
                x_neg = (ch == "-");
            else if (is_digit)
            begin
                x_mag = push_digit(x_mag, ch);
                x_dig = 1'b1;
            end
            else if (is_y && x_dig)
                ph = PH_Y;
            else
                r.event_res = drop_frame();
        end
        else
        begin
            if (is_sign && !y_dig && y_mag == 16'd0)
                y_neg = (ch == "-");
            else if (is_digit)
            begin
                y_mag = push_digit(y_mag, ch);
                y_dig = 1'b1;
            end
            else if (y_dig)
                r.event_res = take_frame();
            else
                r.event_res = drop_frame();
        end
        r.x_offset       = last_x;
        r.y_offset       = last_y;
        r.good_frames    = good_cnt;
        r.dropped_frames = bad_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    // every fourth stretch of items runs with no idle cycles
    function automatic int draw_gap(input int n);
        if ((n / 160) % 4 == 2)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic cmd, input logic [7:0] ch, input bit known,
                             input axofp_pkg::result_t typed);
        int                 gap;
        axofp_pkg::result_t r;
        gap = draw_gap(n_sent);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= ch;
        do
            @(posedge clk);
        while (!s_tready);
        r = parse_item(cmd, ch);
        pending_q.push_back(known ? typed : r);
        n_sent++;
        @(negedge clk);
    endtask

    // now and then a byte of the frame is replaced by line noise
    task automatic send_char(input logic [7:0] ch);
        if ($urandom_range(0, 39) == 0)
            send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
        else
            send_item(CMD_BYTE, ch, 1'b0, '0);
    endtask

    function automatic int draw_len();
        if ($urandom_range(0, 11) == 0)
            return 0;
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(5, 7);
        return $urandom_range(1, 4);
    endfunction

    task automatic send_field(input logic [7:0] letter);
        int n;
        send_char(letter);
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
        repeat (n) send_char($urandom_range(0, 1) ? "-" : "+");
        n = draw_len();
        repeat (n) send_char(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0)
            send_item(CMD_FLUSH, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic send_frame();
        send_field($urandom_range(0, 1) ? "X" : "x");
        send_field($urandom_range(0, 1) ? "Y" : "y");
        case ($urandom_range(0, 3))
            0: ;    // the next frame's letter closes this one
            1: send_item(CMD_FLUSH, 8'($urandom_range(0, 255)), 1'b0, '0);
            2: send_char($urandom_range(0, 1) ? "-" : "+");
            default: send_char(8'($urandom_range(0, 255)));
        endcase
    endtask

    initial
    begin : stim
        int i;
        clear_fields();
        last_x   = 16'd0;
        last_y   = 16'd0;
        good_cnt = 32'd0;
        bad_cnt  = 32'd0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < 25; i++)
            send_item(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].known, dir_rows[i].want);

        while (n_sent < N_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
                1: send_item(CMD_FLUSH, 8'($urandom_range(0, 255)), 1'b0, '0);
                default: send_frame();
            endcase
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial
    begin : sink
        int                 gap;
        axofp_pkg::result_t got;
        axofp_pkg::result_t want;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            // one long hold-off so the block fills and stalls its input
            gap = (n_got == HOLD_AT) ? HOLD_CYCLES : draw_gap(n_got);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.event_res      = m_tuser;
            got.x_offset       = m_tdata[15:0];
            got.y_offset       = m_tdata[31:16];
            got.good_frames    = m_tdata[63:32];
            got.dropped_frames = m_tdata[95:64];
            if (pending_q.size() == 0)
            begin
                n_errors++;
                $display("%0t unexpected item: ev=%0d x=%0d y=%0d good=%0d dropped=%0d",
                         $time, got.event_res, got.x_offset, got.y_offset,
                         got.good_frames, got.dropped_frames);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.event_res !== want.event_res || got.x_offset !== want.x_offset ||
                    got.y_offset !== want.y_offset ||
                    got.good_frames !== want.good_frames ||
                    got.dropped_frames !== want.dropped_frames)
                begin
                    n_errors++;
                    $display({"%0t mismatch on item %0d: expected ev=%0d x=%0d y=%0d",
                              " good=%0d dropped=%0d"},
                             $time, n_got, want.event_res, want.x_offset, want.y_offset,
                             want.good_frames, want.dropped_frames);
                    $display({"%0t                 actual   ev=%0d x=%0d y=%0d",
                              " good=%0d dropped=%0d"},
                             $time, got.event_res, got.x_offset, got.y_offset,
                             got.good_frames, got.dropped_frames);
                end
            end
            n_got++;
            @(negedge clk);
        end
    end

endmodule
